// ----- rtl/slmt_pkg.sv -----
// shared types and constants for the sharded live-set minimum tracker
`default_nettype none

package slmt_pkg;

    localparam int TXN_W  = 16;
    localparam int SNAP_W = 64;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_PUBLISH = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_ENT,
        S_SCAN_CNT,
        S_SCAN_ENT,
        S_SCAN_END
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/slmt_entry_ram.sv -----
// entry store: one write port, two registered read ports
`default_nettype none

module slmt_entry_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 80
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_ra_addr,
    input  wire logic [AW-1:0] i_rb_addr,
    output logic      [DW-1:0] o_ra_data,
    output logic      [DW-1:0] o_rb_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_ra_q;
    logic [DW-1:0] r_rb_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_ra_q <= r_mem[i_ra_addr];
        r_rb_q <= r_mem[i_rb_addr];
    end

    assign o_ra_data = r_ra_q;
    assign o_rb_data = r_rb_q;

endmodule

`default_nettype wire

// ----- rtl/sharded_live_set_min_tracker_core.sv -----
// top level: sharded live-set table with add, swap-remove and minimum publish
//
//  channel  | direction | handshake                  | beat contents
//  ---------+-----------+----------------------------+--------------------------------------
//  request  | in        | i_in_valid / o_in_stall    | op, shard, slot_index, txn_id, snapshot
//  result   | out       | o_out_valid / i_out_stall  | status, landed/moved fields, minimums
//
// add and invalid ops finish after the count read, remove reads the count, then the entry;
// publish walks the count memory shard by shard and reads one entry per cycle through the entry ram.
// reset clears the per-shard count valid flags at once; no clearing pass is needed.
// a finished result waits in the output register while the next request is taken;
// the block holds its last step while that register is full and stalled.
`default_nettype none

module sharded_live_set_min_tracker_core
    import slmt_pkg::*;
#(
    parameter int NUM_SHARDS      = 32,
    parameter int SLOTS_PER_SHARD = 16,
    parameter int ID_BITS         = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_op,
    input  wire logic signed [5:0]   i_shard,
    input  wire logic signed [4:0]   i_slot_index,
    input  wire logic [TXN_W-1:0]    i_txn_id,
    input  wire logic [SNAP_W-1:0]   i_snapshot,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [4:0]               o_landed_shard,
    output logic [3:0]               o_landed_index,
    output logic                     o_moved_valid,
    output logic [TXN_W-1:0]         o_moved_txn,
    output logic [3:0]               o_moved_index,
    output logic [SNAP_W-1:0]        o_min_exact,
    output logic [SNAP_W-1:0]        o_min_published
);

    localparam int SW    = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;
    localparam int SLW   = $clog2(SLOTS_PER_SHARD);
    localparam int CW    = $clog2(SLOTS_PER_SHARD + 1);
    localparam int TOTAL = NUM_SHARDS * SLOTS_PER_SHARD;
    localparam int AW    = $clog2(TOTAL);
    localparam int IDW   = (ID_BITS < TXN_W) ? ID_BITS : TXN_W;
    localparam int EW    = IDW + SNAP_W;

    localparam logic [AW-1:0] SLOTS_A    = AW'(SLOTS_PER_SHARD);
    localparam logic [SW-1:0] LAST_SHARD = SW'(NUM_SHARDS - 1);

    // state and item registers
    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_op;
    logic [SW-1:0]      r_shard;
    logic               r_shard_ok;
    logic signed [4:0]  r_idx;
    logic [IDW-1:0]     r_id;
    logic [SNAP_W-1:0]  r_snap;
    logic [SLW-1:0]     r_last;

    // shard counts
    logic [CW-1:0]      r_cnt_mem [NUM_SHARDS];
    logic               r_cnt_vld [NUM_SHARDS];
    logic [CW-1:0]      r_cnt_rd;
    logic               r_cnt_rv;
    logic [SW-1:0]      cnt_raddr;
    logic [CW-1:0]      cnt;
    logic               cnt_we;
    logic [CW-1:0]      cnt_wdata;

    // entry store access
    logic               ent_we;
    logic [AW-1:0]      ent_waddr;
    logic [EW-1:0]      ent_wdata;
    logic [AW-1:0]      ra_addr;
    logic [AW-1:0]      rb_addr;
    logic [EW-1:0]      ent_a;
    logic [EW-1:0]      ent_b;

    // scan
    logic [SW-1:0]      r_ss;
    logic [CW-1:0]      r_si;
    logic               r_rd_vld;
    logic [SNAP_W-1:0]  r_min;
    logic               r_any;
    logic [SNAP_W-1:0]  n_min;
    logic               n_any;
    logic [SNAP_W-1:0]  r_pub;
    logic               scan_st;
    logic               scan_issue;
    logic               ss_inc;
    logic               pub_load;

    // output register
    logic               r_ovld;
    t_status            r_o_status;
    logic [4:0]         r_o_landed_shard;
    logic [3:0]         r_o_landed_index;
    logic               r_o_moved_valid;
    logic [TXN_W-1:0]   r_o_moved_txn;
    logic [3:0]         r_o_moved_index;
    logic [SNAP_W-1:0]  r_o_min_exact;
    logic [SNAP_W-1:0]  r_o_min_pub;

    t_status            n_o_status;
    logic [4:0]         n_o_landed_shard;
    logic [3:0]         n_o_landed_index;
    logic               n_o_moved_valid;
    logic [TXN_W-1:0]   n_o_moved_txn;
    logic [3:0]         n_o_moved_index;
    logic [SNAP_W-1:0]  n_o_min_exact;
    logic [SNAP_W-1:0]  n_o_min_pub;
    logic               out_load;

    // derived
    logic               accept;
    logic               out_free;
    logic [AW-1:0]      base_cur;
    logic [AW-1:0]      base_scan;
    logic [SLW-1:0]     cnt_last;
    logic [SLW-1:0]     rb_slot;
    logic               idx_ok;
    logic               cnt_full;
    logic               scan_more;
    logic               moving;
    logic [IDW-1:0]     ent_a_id;
    logic [IDW-1:0]     ent_b_id;
    logic [SNAP_W-1:0]  ent_a_snap;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovld || !i_out_stall;
    assign scan_st  = (r_state == S_SCAN_CNT) || (r_state == S_SCAN_ENT) ||
                      (r_state == S_SCAN_END);

    assign cnt       = r_cnt_rv ? r_cnt_rd : '0;
    assign cnt_last  = SLW'(cnt - CW'(1));
    assign idx_ok    = !r_idx[4] && (32'(r_idx[3:0]) < 32'(cnt));
    assign cnt_full  = 32'(cnt) >= SLOTS_PER_SHARD;
    assign scan_more = 32'(r_si) < 32'(cnt);
    assign moving    = 32'(r_idx[3:0]) != 32'(r_last);

    assign base_cur  = AW'(r_shard) * SLOTS_A;
    assign base_scan = AW'(r_ss) * SLOTS_A;
    assign rb_slot   = (r_state == S_ENT) ? r_last : cnt_last;

    assign cnt_raddr = (r_state == S_IDLE) ? i_shard[SW-1:0] : (scan_st ? r_ss : r_shard);
    assign ra_addr   = scan_st ? base_scan + AW'(r_si[SLW-1:0])
                               : base_cur + AW'(r_idx[3:0]);
    assign rb_addr   = base_cur + AW'(rb_slot);

    assign ent_a_id   = ent_a[EW-1:SNAP_W];
    assign ent_b_id   = ent_b[EW-1:SNAP_W];
    assign ent_a_snap = ent_a[SNAP_W-1:0];

    slmt_entry_ram #(
        .DEPTH (TOTAL),
        .AW    (AW),
        .DW    (EW)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_we      (ent_we),
        .i_waddr   (ent_waddr),
        .i_wdata   (ent_wdata),
        .i_ra_addr (ra_addr),
        .i_rb_addr (rb_addr),
        .o_ra_data (ent_a),
        .o_rb_data (ent_b)
    );

    // running minimum over entries read during the scan
    always_comb begin
        n_min = r_min;
        n_any = r_any;
        if (r_rd_vld) begin
            n_any = 1'b1;
            if (ent_a_snap < r_min) begin
                n_min = ent_a_snap;
            end
        end
    end

    always_comb begin
        n_state          = r_state;
        cnt_we           = 1'b0;
        cnt_wdata        = CW'(cnt + CW'(1));
        ent_we           = 1'b0;
        ent_waddr        = base_cur + AW'(cnt);
        ent_wdata        = {r_id, r_snap};
        out_load         = 1'b0;
        scan_issue       = 1'b0;
        ss_inc           = 1'b0;
        pub_load         = 1'b0;
        n_o_status       = ST_BAD;
        n_o_landed_shard = '0;
        n_o_landed_index = '0;
        n_o_moved_valid  = 1'b0;
        n_o_moved_txn    = '0;
        n_o_moved_index  = '0;
        n_o_min_exact    = '0;
        n_o_min_pub      = r_pub;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == OP_PUBLISH) ? S_SCAN_CNT : S_CNT;
                end
            end
            S_CNT: begin
                if (r_op == OP_REMOVE && r_shard_ok && idx_ok) begin
                    n_state = S_ENT;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_op == OP_ADD && r_shard_ok) begin
                        if (cnt_full) begin
                            n_o_status = ST_FULL;
                        end else begin
                            n_o_status       = ST_DONE;
                            ent_we           = 1'b1;
                            cnt_we           = 1'b1;
                            n_o_landed_shard = 5'(r_shard);
                            n_o_landed_index = 4'(cnt);
                        end
                    end
                end
            end
            S_ENT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (ent_a_id == r_id) begin
                        n_o_status = ST_DONE;
                        cnt_we     = 1'b1;
                        cnt_wdata  = CW'(r_last);
                        if (moving) begin
                            // last entry fills the freed slot
                            ent_we          = 1'b1;
                            ent_waddr       = base_cur + AW'(r_idx[3:0]);
                            ent_wdata       = ent_b;
                            n_o_moved_valid = 1'b1;
                            n_o_moved_txn   = TXN_W'(ent_b_id);
                            n_o_moved_index = 4'(r_idx[3:0]);
                        end
                    end
                end
            end
            S_SCAN_CNT: begin
                n_state = S_SCAN_ENT;
            end
            S_SCAN_ENT: begin
                if (scan_more) begin
                    scan_issue = 1'b1;
                end else if (r_ss == LAST_SHARD) begin
                    n_state = S_SCAN_END;
                end else begin
                    ss_inc  = 1'b1;
                    n_state = S_SCAN_CNT;
                end
            end
            S_SCAN_END: begin
                // last entry read is already folded into r_min on the way here
                if (out_free) begin
                    out_load      = 1'b1;
                    pub_load      = 1'b1;
                    n_state       = S_IDLE;
                    n_o_status    = ST_DONE;
                    n_o_min_exact = n_min;
                    n_o_min_pub   = n_any ? n_min : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_pub    <= '0;
            for (int s = 0; s < NUM_SHARDS; s++) begin
                r_cnt_vld[s] <= 1'b0;
            end
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
            r_rd_vld <= scan_issue;
            if (pub_load) begin
                r_pub <= n_o_min_pub;
            end
            if (cnt_we) begin
                r_cnt_vld[r_shard] <= 1'b1;
            end
        end
    end

    // count memory, registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_shard] <= cnt_wdata;
        end
        r_cnt_rd <= r_cnt_mem[cnt_raddr];
        r_cnt_rv <= r_cnt_vld[cnt_raddr];
    end

    // item and scan payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_op;
            r_shard    <= i_shard[SW-1:0];
            r_shard_ok <= !i_shard[5] && (32'(i_shard[4:0]) < NUM_SHARDS);
            r_idx      <= i_slot_index;
            r_id       <= i_txn_id[IDW-1:0];
            r_snap     <= i_snapshot;
            r_ss       <= '0;
            r_min      <= '1;
            r_any      <= 1'b0;
        end else begin
            r_min <= n_min;
            r_any <= n_any;
            if (ss_inc) begin
                r_ss <= r_ss + SW'(1);
            end
        end
        if (r_state == S_CNT) begin
            r_last <= cnt_last;
        end
        if (r_state == S_SCAN_CNT) begin
            r_si <= '0;
        end else if (scan_issue) begin
            r_si <= r_si + CW'(1);
        end
        if (out_load) begin
            r_o_status       <= n_o_status;
            r_o_landed_shard <= n_o_landed_shard;
            r_o_landed_index <= n_o_landed_index;
            r_o_moved_valid  <= n_o_moved_valid;
            r_o_moved_txn    <= n_o_moved_txn;
            r_o_moved_index  <= n_o_moved_index;
            r_o_min_exact    <= n_o_min_exact;
            r_o_min_pub      <= n_o_min_pub;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovld;
    assign o_status        = r_o_status;
    assign o_landed_shard  = r_o_landed_shard;
    assign o_landed_index  = r_o_landed_index;
    assign o_moved_valid   = r_o_moved_valid;
    assign o_moved_txn     = r_o_moved_txn;
    assign o_moved_index   = r_o_moved_index;
    assign o_min_exact     = r_o_min_exact;
    assign o_min_published = r_o_min_pub;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the sharded live-set minimum tracker: directed and random table traffic
module tb_top;
    import slmt_pkg::*;

    localparam int NUM_SHARDS      = 32;
    localparam int SLOTS_PER_SHARD = 16;
    localparam int CYCLE_LIMIT     = 2_000_000;
    // longest single op is a publish over a full table
    localparam int DRAIN_CYCLES    = 1000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_status           status;
        logic [4:0]        landed_shard;
        logic [3:0]        landed_index;
        logic              moved_valid;
        logic [TXN_W-1:0]  moved_txn;
        logic [3:0]        moved_index;
        logic [SNAP_W-1:0] min_exact;
        logic [SNAP_W-1:0] min_published;
    } t_table_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_op = '0;
    logic signed [5:0]       i_shard = '0;
    logic signed [4:0]       i_slot_index = '0;
    logic [TXN_W-1:0]        i_txn_id = '0;
    logic [SNAP_W-1:0]       i_snapshot = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [1:0]              o_status;
    logic [4:0]              o_landed_shard;
    logic [3:0]              o_landed_index;
    logic                    o_moved_valid;
    logic [TXN_W-1:0]        o_moved_txn;
    logic [3:0]              o_moved_index;
    logic [SNAP_W-1:0]       o_min_exact;
    logic [SNAP_W-1:0]       o_min_published;

    // shadow of the live table
    logic [TXN_W-1:0]  tbl_ids   [NUM_SHARDS][SLOTS_PER_SHARD];
    logic [SNAP_W-1:0] tbl_snaps [NUM_SHARDS][SLOTS_PER_SHARD];
    int                tbl_counts[NUM_SHARDS];
    logic [SNAP_W-1:0] tbl_floor;

    t_table_result pending_results[$];
    t_table_result got_want;
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  rx_burst_left = 0;
    int  rx_hold_left = 0;

    sharded_live_set_min_tracker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_shard        (i_shard),
        .i_slot_index   (i_slot_index),
        .i_txn_id       (i_txn_id),
        .i_snapshot     (i_snapshot),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_landed_shard (o_landed_shard),
        .o_landed_index (o_landed_index),
        .o_moved_valid  (o_moved_valid),
        .o_moved_txn    (o_moved_txn),
        .o_moved_index  (o_moved_index),
        .o_min_exact    (o_min_exact),
        .o_min_published(o_min_published)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[sharded_live_set_min_tracker_core] ERROR");
            $finish;
        end
    end

    function automatic t_table_result apply_table_op(input logic [1:0] op,
                                                     input logic signed [5:0] sh,
                                                     input logic signed [4:0] idx,
                                                     input logic [TXN_W-1:0] id,
                                                     input logic [SNAP_W-1:0] snap);
        t_table_result r;
        int s, c, i, last;
        logic [SNAP_W-1:0] lo;
        bit any;
        r.status = ST_BAD;
        r.landed_shard = '0;
        r.landed_index = '0;
        r.moved_valid = 1'b0;
        r.moved_txn = '0;
        r.moved_index = '0;
        r.min_exact = '0;
        s = int'(sh);
        i = int'(idx);
        case (op)
            OP_ADD: begin
                if (s >= 0 && s < NUM_SHARDS) begin
                    c = tbl_counts[s];
                    if (c >= SLOTS_PER_SHARD) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_ids[s][c] = id;
                        tbl_snaps[s][c] = snap;
                        tbl_counts[s] = c + 1;
                        r.status = ST_DONE;
                        r.landed_shard = 5'(s);
                        r.landed_index = 4'(c);
                    end
                end
            end
            OP_REMOVE: begin
                if (s >= 0 && s < NUM_SHARDS) begin
                    c = tbl_counts[s];
                    if (i >= 0 && i < c && tbl_ids[s][i] == id) begin
                        last = c - 1;
                        // swap the shard's tail entry into the freed slot
                        if (i != last) begin
                            tbl_ids[s][i] = tbl_ids[s][last];
                            tbl_snaps[s][i] = tbl_snaps[s][last];
                            r.moved_valid = 1'b1;
                            r.moved_txn = tbl_ids[s][i];
                            r.moved_index = 4'(i);
                        end
                        tbl_counts[s] = last;
                        r.status = ST_DONE;
                    end
                end
            end
            OP_PUBLISH: begin
                lo = '1;
                any = 1'b0;
                for (int k = 0; k < NUM_SHARDS; k++) begin
                    for (int j = 0; j < tbl_counts[k]; j++) begin
                        any = 1'b1;
                        if (tbl_snaps[k][j] < lo) lo = tbl_snaps[k][j];
                    end
                end
                r.min_exact = lo;
                tbl_floor = any ? lo : '0;
                r.status = ST_DONE;
            end
            default: ;
        endcase
        r.min_published = tbl_floor;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [SNAP_W-1:0] rand_snapshot();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2, 3, 4: return SNAP_W'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result side: random stall bursts, plus a long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_burst_left > 0) begin
            rx_burst_left--;
            i_out_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            rx_burst_left = $urandom_range(0, 15);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                err_cnt++;
            end else begin
                got_want = pending_results.pop_front();
                check_field("status", 64'(got_want.status), 64'(o_status));
                check_field("landed_shard", 64'(got_want.landed_shard), 64'(o_landed_shard));
                check_field("landed_index", 64'(got_want.landed_index), 64'(o_landed_index));
                check_field("moved_valid", 64'(got_want.moved_valid), 64'(o_moved_valid));
                check_field("moved_txn", 64'(got_want.moved_txn), 64'(o_moved_txn));
                check_field("moved_index", 64'(got_want.moved_index), 64'(o_moved_index));
                check_field("min_exact", got_want.min_exact, o_min_exact);
                check_field("min_published", got_want.min_published, o_min_published);
            end
        end
    end

    task automatic send_req(input logic [1:0] op, input logic signed [5:0] sh,
                            input logic signed [4:0] idx, input logic [TXN_W-1:0] id,
                            input logic [SNAP_W-1:0] snap);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_shard      <= sh;
        i_slot_index <= idx;
        i_txn_id     <= id;
        i_snapshot   <= snap;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_table_op(op, sh, idx, id, snap));
    endtask

    task automatic send_random_item();
        int pick, s, tries, i;
        logic [1:0] op;
        logic signed [5:0] sh;
        logic signed [4:0] idx;
        logic [TXN_W-1:0] id;
        logic [SNAP_W-1:0] snap;
        pick = $urandom_range(0, 99);
        op   = OP_ADD;
        sh   = 6'($urandom);
        idx  = 5'($urandom);
        id   = TXN_W'($urandom);
        snap = rand_snapshot();
        if (pick < 45) begin
            // half of the adds go to a few hot shards so they fill up
            sh = $urandom_range(0, 1) ? 6'($urandom_range(0, 3) * 8 + 7)
                                      : 6'($urandom_range(0, NUM_SHARDS - 1));
        end else if (pick < 88) begin
            s = $urandom_range(0, NUM_SHARDS - 1);
            tries = 0;
            while (tbl_counts[s] == 0 && tries < NUM_SHARDS) begin
                s = (s + 1) % NUM_SHARDS;
                tries++;
            end
            sh = 6'(s);
            if (tbl_counts[s] != 0) begin
                op  = OP_REMOVE;
                i   = $urandom_range(0, tbl_counts[s] - 1);
                idx = 5'(i);
                id  = tbl_ids[s][i];
                if (pick >= 80) begin
                    case ($urandom_range(0, 2))
                        0: id = id ^ TXN_W'($urandom_range(1, 65535));
                        1: idx = 5'($urandom_range(tbl_counts[s], 31));
                        default: sh = 6'($urandom_range(32, 63));
                    endcase
                end
            end
        end else if (pick < 95) begin
            op = OP_PUBLISH;
        end else begin
            op = 2'($urandom);
        end
        send_req(op, sh, idx, id, snap);
    endtask

    task automatic test_basic_ops();
        send_req(OP_PUBLISH, 6'sd0, 5'sd0, '0, '0);
        send_req(OP_ADD, 6'sd31, -5'sd1, 16'hFFFF, '1);
        // the only live value is all ones: published as is
        send_req(OP_PUBLISH, -6'sd1, 5'sd15, 16'hFFFF, '1);
        send_req(OP_ADD, 6'sd0, 5'sd0, 16'h0000, '0);
        send_req(OP_ADD, 6'sd0, -5'sd16, 16'hA5A5, 64'd7);
        send_req(OP_REMOVE, 6'sd0, 5'sd0, 16'h0000, '0);
        send_req(OP_REMOVE, 6'sd0, 5'sd0, 16'h5A5A, '1);
        send_req(OP_REMOVE, 6'sd0, 5'sd1, 16'hA5A5, '0);
        send_req(OP_REMOVE, -6'sd1, -5'sd1, 16'hA5A5, '0);
        send_req(OP_ADD, -6'sd32, 5'sd3, 16'h1234, 64'd9);
        send_req(OP_UNUSED, -6'sd1, -5'sd1, 16'hFFFF, '1);
        // removing the tail entry moves nothing
        send_req(OP_REMOVE, 6'sd0, 5'sd0, 16'hA5A5, '0);
        send_req(OP_REMOVE, 6'sd31, 5'sd0, 16'hFFFF, '0);
        send_req(OP_PUBLISH, 6'sd0, 5'sd0, '0, '0);
    endtask

    task automatic test_full_shard();
        for (int k = 0; k <= SLOTS_PER_SHARD; k++)
            send_req(OP_ADD, 6'sd16, 5'sd0, TXN_W'(16'h0100 + k), SNAP_W'(100 - k));
        send_req(OP_PUBLISH, 6'sd0, 5'sd0, '0, '0);
    endtask

    task automatic test_random_traffic(input int n);
        for (int k = 0; k < n; k++) begin
            // quiet stretches between idling stretches
            tx_idle_en = (k % 150) < 100;
            rx_idle_en = (k % 150) < 100;
            send_random_item();
        end
    endtask

    task automatic test_output_hold(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_left = 300;
        for (int k = 0; k < n; k++) send_random_item();
    endtask

    task automatic test_closing_run(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int k = 0; k < n; k++) send_random_item();
    endtask

    initial begin
        for (int s = 0; s < NUM_SHARDS; s++) tbl_counts[s] = 0;
        tbl_floor = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_full_shard();
        test_random_traffic(600);
        test_output_hold(40);
        test_closing_run(160);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[sharded_live_set_min_tracker_core] OK");
        end else begin
            $display("[sharded_live_set_min_tracker_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/slmt_pkg.sv
rtl/slmt_entry_ram.sv
rtl/sharded_live_set_min_tracker_core.sv
tb/tb_top.sv
